FILE: rtl/adaptive_range_encoder_defines.svh
// assertion macros shared by the encoder rtl
`ifndef ADAPTIVE_RANGE_ENCODER_DEFINES_SVH
`define ADAPTIVE_RANGE_ENCODER_DEFINES_SVH

// condition must never hold outside reset
`define ARE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ARE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ARE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/are_pkg.sv
// package with constants and types of the adaptive range encoder
`timescale 1ns / 1ps
package are_pkg;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int FREQ_W = 17;
  localparam logic [31:0] TOP_LIMIT = 32'h0001_0000;
  localparam logic [31:0] CARRY_MASK = 32'h00ff_0000;
  localparam logic [16:0] TOTAL_MAX = 17'h0_ffff;

  typedef enum logic [10:0] {
    ST_INIT = 11'b000_0000_0001,
    ST_IDLE = 11'b000_0000_0010,
    ST_FLUSH = 11'b000_0000_0100,
    ST_NORM = 11'b000_0000_1000,
    ST_DIV = 11'b000_0001_0000,
    ST_RDS = 11'b000_0010_0000,
    ST_RDS1 = 11'b000_0100_0000,
    ST_MUL1 = 11'b000_1000_0000,
    ST_MUL2 = 11'b001_0000_0000,
    ST_INC = 11'b010_0000_0000,
    ST_RESC = 11'b100_0000_0000
  } are_state_t;
endpackage

FILE: rtl/adaptive_range_encoder.sv
// adaptive order-0 carry-less range encoder, table in one synchronous memory
// throughput: one item at a time; an encode runs a 32-step divider, then updates the table
//   one entry a cycle, and both encode and flush can be held by output stalls;
//   when the table is halved it is rewritten one memory entry a cycle
// reset: low 0, range all ones; an initialization pass writes entry i with value i
//   and loads the table before the first item is taken
`timescale 1ns / 1ps
`include "adaptive_range_encoder_defines.svh"
module adaptive_range_encoder
  import are_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_sym,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  localparam int AW = $clog2(SYMBOL_COUNT + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(SYMBOL_COUNT);
  localparam logic [AW-1:0] MAX_SYM = AW'(SYMBOL_COUNT - 1);

  are_state_t state_r, state_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] range_r, range_nxt;
  logic [FREQ_W-1:0] total_r, total_nxt;
  logic [FREQ_W-1:0] rem_r, rem_nxt;
  logic [FREQ_W-1:0] cum_s_r, cum_s_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [FREQ_W-1:0] prev_r, prev_nxt;
  logic [AW-1:0] sym_r, sym_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] k_r, k_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic out_last_r, out_last_nxt;

  // table memory
  logic [FREQ_W-1:0] mem [SYMBOL_COUNT+1];
  logic [FREQ_W-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [FREQ_W-1:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // helpers for normalization, division and rescale
  logic out_free;
  logic [31:0] l16, rng_lim, rng_sh;
  logic [32:0] rng_sum;
  logic [FREQ_W:0] rem_sh;
  logic [FREQ_W-1:0] divisor, half, resc_val, inc_val;
  logic [48:0] prod;
  logic [AW-1:0] sym_sat;

  assign out_free = !out_valid_r || !out_stall;
  assign l16 = {16'h0, low_r[15:0]};
  assign rng_sum = {1'b0, range_r} + {1'b0, l16};
  assign rng_lim = ((low_r & CARRY_MASK) == CARRY_MASK && rng_sum >= {1'b0, TOP_LIMIT})
                   ? (TOP_LIMIT - l16) : range_r;
  assign rng_sh = {rng_lim[23:0], 8'h00};
  assign divisor = (total_r == '0) ? FREQ_W'(1) : total_r;
  assign rem_sh = {rem_r, range_r[31]};
  assign half = rd_data_r >> 1;
  assign resc_val = (idx_r != '0 && half <= prev_r) ? prev_r + FREQ_W'(1) : half;
  assign inc_val = rd_data_r + FREQ_W'(1);
  assign sym_sat = ({1'b0, in_sym} >= 9'(SYMBOL_COUNT)) ? MAX_SYM : AW'(in_sym);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    low_nxt = low_r;
    range_nxt = range_r;
    total_nxt = total_r;
    rem_nxt = rem_r;
    cum_s_nxt = cum_s_r;
    freq_nxt = freq_r;
    prev_nxt = prev_r;
    sym_nxt = sym_r;
    idx_nxt = idx_r;
    step_nxt = step_r;
    k_nxt = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    rd_addr = idx_r;
    wr_addr = idx_r;
    wr_data = '0;
    wr_en = 1'b0;
    prod = '0;
    unique case (state_r)
      ST_INIT: begin
        wr_en = 1'b1;
        wr_data = FREQ_W'(idx_r);
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_IDX) begin
          total_nxt = FREQ_W'(SYMBOL_COUNT);
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          k_nxt = '0;
          sym_nxt = sym_sat;
          state_nxt = in_op ? ST_FLUSH : ST_NORM;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt = low_r[31:24];
          out_last_nxt = (k_r == 2'd3);
          low_nxt = {low_r[23:0], 8'h00};
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NORM: begin
        if (range_r >= TOP_LIMIT || k_r == 2'd2) begin
          rem_nxt = '0;
          step_nxt = '0;
          state_nxt = ST_DIV;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt = low_r[31:24];
          out_last_nxt = !(k_r == 2'd0 && rng_sh < TOP_LIMIT);
          low_nxt = {low_r[23:0], 8'h00};
          range_nxt = rng_sh;
          k_nxt = k_r + 2'd1;
        end
      end
      ST_DIV: begin
        // one quotient bit a cycle, quotient shifts into range
        if (rem_sh >= {1'b0, divisor}) begin
          rem_nxt = FREQ_W'(rem_sh - {1'b0, divisor});
          range_nxt = {range_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[FREQ_W-1:0];
          range_nxt = {range_r[30:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = ST_RDS;
        end
      end
      ST_RDS: begin
        rd_addr = sym_r;
        state_nxt = ST_RDS1;
      end
      ST_RDS1: begin
        cum_s_nxt = rd_data_r;
        rd_addr = sym_r + AW'(1);
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        freq_nxt = rd_data_r - cum_s_r;
        prod = {32'h0, cum_s_r} * {17'h0, range_r};
        low_nxt = low_r + prod[31:0];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod = {32'h0, freq_r} * {17'h0, range_r};
        range_nxt = prod[31:0];
        rd_addr = sym_r + AW'(1);
        idx_nxt = sym_r + AW'(1);
        state_nxt = ST_INC;
      end
      ST_INC: begin
        // read ahead one entry while writing back the current one
        wr_en = 1'b1;
        wr_data = inc_val;
        rd_addr = idx_r + AW'(1);
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_IDX) begin
          total_nxt = inc_val;
          rd_addr = '0;
          idx_nxt = '0;
          state_nxt = (inc_val > TOTAL_MAX) ? ST_RESC : ST_IDLE;
        end
      end
      ST_RESC: begin
        // halve and keep strictly increasing
        wr_en = 1'b1;
        wr_data = resc_val;
        prev_nxt = resc_val;
        rd_addr = idx_r + AW'(1);
        idx_nxt = idx_r + AW'(1);
        if (idx_r == LAST_IDX) begin
          total_nxt = resc_val;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      idx_r <= '0;
      low_r <= '0;
      range_r <= 32'hffff_ffff;
      total_r <= FREQ_W'(SYMBOL_COUNT);
      out_valid_r <= 1'b0;
      k_r <= '0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      low_r <= low_nxt;
      range_r <= range_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
      k_r <= k_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    cum_s_r <= cum_s_nxt;
    freq_r <= freq_nxt;
    prev_r <= prev_nxt;
    sym_r <= sym_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

  // checks
  `ARE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall, state_r != ST_IDLE, "accepted item did not start work")
  `ARE_ASSERT_IMPL(a_total_nonzero, clk, rst_n, state_r != ST_INIT, total_r != '0, "table total is zero")
  `ARE_ASSERT_IMPL(a_norm_bound, clk, rst_n, state_r == ST_NORM && k_r == 2'd2, range_r >= TOP_LIMIT, "range still small after two bytes")
endmodule

FILE: sim/tb_adaptive_range_encoder.sv
// self-checking testbench of the adaptive range encoder
`timescale 1ns / 1ps
module tb_adaptive_range_encoder;
  import are_pkg::*;

  localparam int SYM_N = SYMBOL_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 2 * (SYM_N + 1) + 200;
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_byte_t;

  // directed row: fixed rows carry their expected bytes
  typedef struct {
    logic       op;
    logic [7:0] sym;
    bit         fixed;
    int         n_bytes;
    logic [7:0] b0, b1, b2, b3;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_sym;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;

  adaptive_range_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_sym(in_sym),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_last(out_last)
  );

  // predictor state
  logic [31:0] code_low;
  logic [31:0] code_range;
  logic [16:0] cum_tab [0:SYM_N];
  code_byte_t  staged_q [$];
  code_byte_t  pending_q [$];
  int          err_count;
  int unsigned cycle_count;

  dir_row_t dir_rows [] = '{
    '{OP_FLUSH, 8'h00, 1, 4, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h00, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'hff, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h80, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h01, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'hfe, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h55, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'haa, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h0f, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'hf0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_FLUSH, 8'hff, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_FLUSH, 8'h00, 1, 4, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h33, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'hcc, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h7f, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_ENCODE, 8'h01, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{OP_FLUSH, 8'h00, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_adaptive_range_encoder: done, errors");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // predicted code bytes of one item go to staged_q
  task automatic predict_code(input logic op, input logic [7:0] sym);
    int unsigned s;
    int k;
    int n;
    logic [31:0] total;
    logic [31:0] l16;
    staged_q.delete();
    // flush: four bytes of low, most significant first
    if (op == OP_FLUSH) begin
      for (k = 0; k < 4; k++) begin
        staged_q.push_back('{code_low[31:24], k == 3});
        code_low = code_low << 8;
      end
      return;
    end
    s = sym;
    if (s >= SYM_N) s = SYM_N - 1;
    // normalization with carry-boundary limit
    n = 0;
    for (k = 0; k < 2 && code_range < TOP_LIMIT; k++) begin
      l16 = code_low & 32'h0000_ffff;
      if ((code_low & CARRY_MASK) == CARRY_MASK && code_range + l16 >= TOP_LIMIT)
        code_range = TOP_LIMIT - l16;
      staged_q.push_back('{code_low[31:24], 1'b0});
      n++;
      code_low = code_low << 8;
      code_range = code_range << 8;
    end
    if (n > 0) staged_q[n - 1].last = 1'b1;
    // interval scaling
    total = 32'(cum_tab[SYM_N]);
    if (total == 0) total = 1;
    code_range = code_range / total;
    code_low = code_low + 32'(cum_tab[s]) * code_range;
    code_range = code_range * (32'(cum_tab[s + 1]) - 32'(cum_tab[s]));
    // model update and halving
    for (int i = s + 1; i <= SYM_N; i++) cum_tab[i] = cum_tab[i] + 17'd1;
    if (cum_tab[SYM_N] > TOTAL_MAX) begin
      cum_tab[0] = cum_tab[0] >> 1;
      for (int i = 1; i <= SYM_N; i++) begin
        cum_tab[i] = cum_tab[i] >> 1;
        if (cum_tab[i] <= cum_tab[i - 1]) cum_tab[i] = cum_tab[i - 1] + 17'd1;
      end
    end
  endtask

  // drive one item, hold until accepted; valid stays high for the caller
  task automatic send_item(input logic op, input logic [7:0] sym, input bit fixed = 0,
                           input code_byte_t fixed_q [$] = {});
    in_valid = 1'b1;
    in_op = op;
    in_sym = sym;
    do @(posedge clk); while (in_stall);
    predict_code(op, sym);
    if (fixed) begin
      foreach (fixed_q[i]) pending_q.push_back(fixed_q[i]);
    end else begin
      foreach (staged_q[i]) pending_q.push_back(staged_q[i]);
    end
    @(negedge clk);
  endtask

  // random gap between bursts
  task automatic idle_gap(input int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stall pattern: the style is redrawn at random from four styles
  int stall_style;
  always @(negedge clk) begin
    if (cycle_count % 64 == 0) stall_style <= $urandom_range(3, 0);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99, 0) < 30);
      2: out_stall <= (cycle_count % 4 != 0);
      default: out_stall <= ($urandom_range(99, 0) < 80);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report("unexpected byte", out_byte, 0);
      end else begin
        if (out_byte !== pending_q[0].code) report("out_byte", out_byte, pending_q[0].code);
        if (out_last !== pending_q[0].last) report("out_last", out_last, pending_q[0].last);
        void'(pending_q.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    code_byte_t fq [$];
    int burst;
    err_count = 0;
    cycle_count = 0;
    stall_style = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ENCODE;
    in_sym = 8'h00;
    out_stall = 1'b0;
    code_low = 32'h0;
    code_range = 32'hffff_ffff;
    for (int i = 0; i <= SYM_N; i++) cum_tab[i] = 17'(i);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    foreach (dir_rows[r]) begin
      fq.delete();
      if (dir_rows[r].n_bytes == 4) begin
        fq.push_back('{dir_rows[r].b0, 1'b0});
        fq.push_back('{dir_rows[r].b1, 1'b0});
        fq.push_back('{dir_rows[r].b2, 1'b0});
        fq.push_back('{dir_rows[r].b3, 1'b1});
      end
      send_item(dir_rows[r].op, dir_rows[r].sym, dir_rows[r].fixed, fq);
      if (r % 3 == 2) idle_gap(6);
    end

    // random bursts, mostly encodes with an occasional flush
    for (int i = 0; i < 100; ) begin
      burst = $urandom_range(8, 1);
      for (int b = 0; b < burst; b++, i++)
        send_item(($urandom_range(15, 0) == 0) ? OP_FLUSH : OP_ENCODE,
                  8'($urandom_range(255, 0)));
      idle_gap(10);
    end
    send_item(OP_FLUSH, 8'($urandom_range(255, 0)));
    in_valid = 1'b0;

    // drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_adaptive_range_encoder: done, clean");
    else
      $display("tb_adaptive_range_encoder: done, errors");
    $finish;
  end

endmodule
